// ===== sv/kve_pkg.sv =====
package kve_pkg;

  localparam int POS_W    = 32;
  localparam int ORI_W    = 18;
  localparam int OUT_W    = 32;
  localparam int STEP_W   = 16;
  localparam int K_W      = 50;   // coefficient width, 32 fraction bits
  localparam int MAG_W    = 40;   // multiplier operand magnitude
  localparam int PROD_W   = 90;
  localparam int DIV_N_W  = 66;
  localparam int DIV_D_W  = 34;
  localparam int SKEW_W   = 38;
  localparam int ACC_W    = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd656;

  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREV_STEP = 2'd1;

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[OUT_W-1:0];
    return r;
  endfunction

endpackage

// ===== sv/kve_if.sv =====
interface kve_pose_if;
  logic valid;
  logic ready;
  logic signed [kve_pkg::POS_W-1:0] pos_x, pos_y, pos_z;
  logic signed [kve_pkg::ORI_W-1:0] orient_c0_x, orient_c0_y, orient_c0_z;
  logic signed [kve_pkg::ORI_W-1:0] orient_c1_x, orient_c1_y, orient_c1_z;
  logic signed [kve_pkg::ORI_W-1:0] orient_c2_x, orient_c2_y, orient_c2_z;

  modport source(output valid, pos_x, pos_y, pos_z, orient_c0_x, orient_c0_y, orient_c0_z,
                 orient_c1_x, orient_c1_y, orient_c1_z, orient_c2_x, orient_c2_y,
                 orient_c2_z, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, orient_c0_x, orient_c0_y, orient_c0_z,
               orient_c1_x, orient_c1_y, orient_c1_z, orient_c2_x, orient_c2_y,
               orient_c2_z, output ready);
endinterface

interface kve_vel_if;
  logic valid;
  logic ready;
  logic signed [kve_pkg::OUT_W-1:0] vel_x, vel_y, vel_z;
  logic signed [kve_pkg::OUT_W-1:0] next_vel_x, next_vel_y, next_vel_z;
  logic signed [kve_pkg::OUT_W-1:0] ang_x, ang_y, ang_z;
  logic signed [kve_pkg::OUT_W-1:0] next_ang_x, next_ang_y, next_ang_z;

  modport source(output valid, vel_x, vel_y, vel_z, next_vel_x, next_vel_y, next_vel_z,
                 ang_x, ang_y, ang_z, next_ang_x, next_ang_y, next_ang_z, input ready);
  modport sink(input valid, vel_x, vel_y, vel_z, next_vel_x, next_vel_y, next_vel_z,
               ang_x, ang_y, ang_z, next_ang_x, next_ang_y, next_ang_z, output ready);
endinterface

// ===== sv/kve_div.sv =====
module kve_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [kve_pkg::DIV_N_W-1:0]  num,
  input  logic [kve_pkg::DIV_D_W-1:0]  den,
  output logic                         done,
  output logic [kve_pkg::DIV_N_W-1:0]  quo
);
  localparam int NW = kve_pkg::DIV_N_W;
  localparam int DW = kve_pkg::DIV_D_W;
  localparam int CW = $clog2(NW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW:0]   rem;
  logic [NW-1:0] nsh;
  logic [DW-1:0] dreg;
  logic [DW:0]   trial;
  logic          ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem[DW-1:0], nsh[NW-1]};
  assign ge    = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= '0;
      nsh  <= num;
      dreg <= den;
      quo  <= '0;
    end else if (busy) begin
      rem <= ge ? trial - {1'b0, dreg} : trial;
      nsh <= {nsh[NW-2:0], 1'b0};
      quo <= {quo[NW-2:0], ge};
      cnt <= cnt + 1'b1;
      if (cnt == CW'(NW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ===== sv/kve_mul.sv =====
module kve_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [kve_pkg::MAG_W-1:0]   a,
  input  logic [kve_pkg::K_W-1:0]     c,
  output logic                        done,
  output logic [kve_pkg::PROD_W-1:0]  prod
);
  localparam int AW    = kve_pkg::MAG_W;
  localparam int PW    = kve_pkg::PROD_W;
  localparam int KW    = kve_pkg::K_W;
  localparam int STEPS = AW / 8;
  localparam int CW    = $clog2(STEPS);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [AW-1:0] ash;
  logic [KW-1:0] creg;
  logic [KW+7:0] part;

  // radix-256, most significant byte first
  assign part = creg * ash[AW-1 -: 8];

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      ash  <= a;
      creg <= c;
      prod <= '0;
    end else if (busy) begin
      prod <= {prod[PW-9:0], 8'b0} + PW'(part);
      ash  <= {ash[AW-9:0], 8'b0};
      cnt  <= cnt + 1'b1;
      if (cnt == CW'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ===== sv/kinematic_velocity_estimator.sv =====
// Velocity estimator for a rigid body with prescribed motion.
// pose channel (valid/ready): one new position and orientation per physics step.
// vel channel (valid/ready): one set of twelve saturated Q16.16 velocities per pose.
// cfg port: write cfg_data into step_size (index 0) or prev_step_size (index 1)
// while the block is idle; other indexes are ignored. Zero steps count as 1.
// Each pose runs four restoring divisions for the step coefficients, then 27
// orientation products and 18 scaled differences, all through one radix-256
// multiplier.
// pose.ready is high only while idle; the block takes one pose at a time.
// The result holds on vel until it is transferred; a stalled receiver simply
// keeps the block from taking the next pose.
// Reset clears prior and pending pose to zero and both step registers to 656.
module kinematic_velocity_estimator (
  input  logic                            clk,
  input  logic                            rst,
  kve_pose_if.sink                        pose,
  kve_vel_if.source                       vel,
  input  logic                            cfg_wr_en,
  input  logic [kve_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kve_pkg::STEP_W-1:0]      cfg_data
);
  localparam int PW = kve_pkg::POS_W;
  localparam int OW = kve_pkg::ORI_W;
  localparam int SW = kve_pkg::STEP_W;
  localparam int KW = kve_pkg::K_W;
  localparam int AW = kve_pkg::MAG_W;
  localparam int XW = kve_pkg::PROD_W;
  localparam int NW = kve_pkg::DIV_N_W;
  localparam int DW = kve_pkg::DIV_D_W;
  localparam int SKW = kve_pkg::SKEW_W;
  localparam int CW = kve_pkg::ACC_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_SKEW = 6'b000100,
    S_MUL  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state;

  logic [SW-1:0] step_size, prev_step_size;
  logic [SW-1:0] hz, ohz;
  logic          eq;
  logic          launch;

  logic signed [PW-1:0] np [3];
  logic signed [PW-1:0] pp [3];
  logic signed [PW-1:0] pr [3];
  logic signed [OW-1:0] no  [9];
  logic signed [OW-1:0] po  [9];
  logic signed [OW-1:0] pro [9];

  logic [KW-1:0] kh, kt, ka, kb;
  logic signed [SKW-1:0] s [9];
  logic signed [CW-1:0] v [3];
  logic signed [CW-1:0] nv [3];
  logic signed [CW-1:0] w [3];
  logic signed [CW-1:0] nw [3];

  logic [1:0] dj, sk, cp, tm, pc;
  logic [2:0] op;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size      <= kve_pkg::STEP_RESET;
      prev_step_size <= kve_pkg::STEP_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == kve_pkg::REG_STEP) step_size <= cfg_data;
      else if (cfg_index == kve_pkg::REG_PREV_STEP) prev_step_size <= cfg_data;
    end
  end

  // ---------------- divider operands ----------------
  logic [SW:0]     hsum;
  logic [2*SW:0]   den_a, den_b;
  logic [NW-1:0]   div_n;
  logic [DW-1:0]   div_d;
  logic            div_done;
  logic [NW-1:0]   div_q;

  assign hsum  = {1'b0, hz} + {1'b0, ohz};
  assign den_a = hsum * hz;
  assign den_b = hsum * ohz;

  always_comb begin
    case (dj)
      2'd0: begin
        div_n = NW'(64'h0000_8000_0000_0000) + NW'(hz[SW-1:1]);
        div_d = DW'(hz);
      end
      2'd1: begin
        div_n = NW'(64'h0002_0000_0000_0000) + NW'(hz[SW-1:1]);
        div_d = DW'(hz);
      end
      2'd2: begin
        div_n = (NW'(ohz) << 48) + NW'(den_a[2*SW:1]);
        div_d = DW'(den_a);
      end
      default: begin
        div_n = (NW'(hz) << 48) + NW'(den_b[2*SW:1]);
        div_d = DW'(den_b);
      end
    endcase
  end

  kve_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(launch && state == S_DIV),
    .num  (div_n),
    .den  (div_d),
    .done (div_done),
    .quo  (div_q)
  );

  // ---------------- skew product operands ----------------
  logic [1:0]            drow, arow;
  logic [3:0]            di, ai, s_idx;
  logic signed [OW:0]    dval;
  logic signed [OW-1:0]  aval;
  logic [OW:0]           dmag;
  logic [OW-1:0]         amag;
  logic                  sk_neg;

  always_comb begin
    case (cp)
      2'd0:    begin drow = 2'd2; arow = 2'd1; end
      2'd1:    begin drow = 2'd0; arow = 2'd2; end
      default: begin drow = 2'd1; arow = 2'd0; end
    endcase
    di    = 4'({tm, 1'b0}) + 4'(tm) + 4'(drow);
    ai    = 4'({tm, 1'b0}) + 4'(tm) + 4'(arow);
    s_idx = 4'({sk, 1'b0}) + 4'(sk) + 4'(cp);
    case (sk)
      2'd0:    dval = eq ? (OW+1)'(no[di]) - (OW+1)'(pro[di])
                         : (OW+1)'(no[di]) - (OW+1)'(po[di]);
      2'd1:    dval = (OW+1)'(po[di]) - (OW+1)'(pro[di]);
      default: dval = (OW+1)'(no[di]) - (OW+1)'(po[di]);
    endcase
    aval   = (sk == 2'd2) ? no[ai] : po[ai];
    dmag   = dval[OW] ? -dval : dval;
    amag   = aval[OW-1] ? -aval : aval;
    sk_neg = dval[OW] ^ aval[OW-1];
  end

  // ---------------- scaled difference operands ----------------
  logic signed [AW-1:0] m_a;
  logic [AW-1:0]        m_mag;
  logic [KW-1:0]        m_c;
  logic                 m_sh48, m_skip;
  logic [1:0]           m_dst;   // 0 v, 1 nv, 2 w, 3 nw

  always_comb begin
    m_sh48 = 1'b0;
    m_skip = 1'b0;
    case (op)
      3'd0: begin
        m_a   = eq ? AW'(np[pc]) - AW'(pr[pc]) : AW'(np[pc]) - AW'(pp[pc]);
        m_c   = eq ? kh : ka;
        m_dst = 2'd0;
      end
      3'd1: begin
        m_a    = AW'(pp[pc]) - AW'(pr[pc]);
        m_c    = kb;
        m_dst  = 2'd0;
        m_skip = eq;
      end
      3'd2: begin
        m_a   = AW'(np[pc]) - AW'(pp[pc]);
        m_c   = kt;
        m_dst = 2'd1;
      end
      3'd3: begin
        m_a    = AW'(s[4'(pc)]);
        m_c    = eq ? kh : ka;
        m_dst  = 2'd2;
        m_sh48 = 1'b1;
      end
      3'd4: begin
        m_a    = AW'(s[4'd3 + 4'(pc)]);
        m_c    = kb;
        m_dst  = 2'd2;
        m_sh48 = 1'b1;
        m_skip = eq;
      end
      default: begin
        m_a    = AW'(s[4'd6 + 4'(pc)]);
        m_c    = kt;
        m_dst  = 2'd3;
        m_sh48 = 1'b1;
      end
    endcase
    m_mag = m_a[AW-1] ? -m_a : m_a;
  end

  // ---------------- shared multiplier ----------------
  logic [AW-1:0] mul_a;
  logic [KW-1:0] mul_c;
  logic          mul_done;
  logic [XW-1:0] mul_p;

  assign mul_a = (state == S_SKEW) ? AW'(dmag) : m_mag;
  assign mul_c = (state == S_SKEW) ? KW'(amag) : m_c;

  kve_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(launch && (state == S_SKEW || state == S_MUL)),
    .a    (mul_a),
    .c    (mul_c),
    .done (mul_done),
    .prod (mul_p)
  );

  logic signed [SKW-1:0] sk_term;
  logic [XW:0]           rnd, rsh;
  logic signed [CW-1:0]  m_term;

  always_comb begin
    sk_term = sk_neg ? -$signed({1'b0, mul_p[SKW-2:0]}) : $signed({1'b0, mul_p[SKW-2:0]});
    rnd     = (XW+1)'(mul_p) + (m_sh48 ? (XW+1)'(64'h0000_8000_0000_0000)
                                       : (XW+1)'(64'h0000_0000_8000_0000));
    rsh     = m_sh48 ? (rnd >> 48) : (rnd >> 32);
    m_term  = m_a[AW-1] ? -$signed({1'b0, rsh[CW-2:0]}) : $signed({1'b0, rsh[CW-2:0]});
  end

  // ---------------- sequencer ----------------
  assign pose.ready = (state == S_IDLE);
  assign vel.valid  = (state == S_OUT);

  always_ff @(posedge clk) begin
    launch <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < 3; i++) begin
        pp[i] <= '0;
        pr[i] <= '0;
      end
      for (int i = 0; i < 9; i++) begin
        po[i]  <= '0;
        pro[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (pose.valid) begin
            np[0] <= pose.pos_x;
            np[1] <= pose.pos_y;
            np[2] <= pose.pos_z;
            no[0] <= pose.orient_c0_x;
            no[1] <= pose.orient_c0_y;
            no[2] <= pose.orient_c0_z;
            no[3] <= pose.orient_c1_x;
            no[4] <= pose.orient_c1_y;
            no[5] <= pose.orient_c1_z;
            no[6] <= pose.orient_c2_x;
            no[7] <= pose.orient_c2_y;
            no[8] <= pose.orient_c2_z;
            hz  <= (step_size == '0) ? SW'(1) : step_size;
            ohz <= (prev_step_size == '0) ? SW'(1) : prev_step_size;
            eq  <= (((step_size == '0) ? SW'(1) : step_size) ==
                    ((prev_step_size == '0) ? SW'(1) : prev_step_size));
            for (int i = 0; i < 9; i++) s[i] <= '0;
            for (int i = 0; i < 3; i++) begin
              v[i]  <= '0;
              nv[i] <= '0;
              w[i]  <= '0;
              nw[i] <= '0;
            end
            dj     <= '0;
            launch <= 1'b1;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            case (dj)
              2'd0:    kh <= div_q[KW-1:0];
              2'd1:    kt <= div_q[KW-1:0];
              2'd2:    ka <= div_q[KW-1:0];
              default: kb <= div_q[KW-1:0];
            endcase
            launch <= 1'b1;
            if (dj == 2'd3) begin
              sk    <= '0;
              cp    <= '0;
              tm    <= '0;
              state <= S_SKEW;
            end else begin
              dj <= dj + 1'b1;
            end
          end
        end
        S_SKEW: begin
          if (mul_done) begin
            s[s_idx] <= s[s_idx] + sk_term;
            launch   <= 1'b1;
            if (tm == 2'd2) begin
              tm <= '0;
              if (cp == 2'd2) begin
                cp <= '0;
                if (sk == 2'd2) begin
                  pc    <= '0;
                  op    <= '0;
                  state <= S_MUL;
                end else begin
                  sk <= sk + 1'b1;
                end
              end else begin
                cp <= cp + 1'b1;
              end
            end else begin
              tm <= tm + 1'b1;
            end
          end
        end
        S_MUL: begin
          if (mul_done) begin
            if (!m_skip) begin
              case (m_dst)
                2'd0:    v[pc]  <= v[pc] + m_term;
                2'd1:    nv[pc] <= nv[pc] + m_term;
                2'd2:    w[pc]  <= w[pc] + m_term;
                default: nw[pc] <= nw[pc] + m_term;
              endcase
            end
            if (op == 3'd5) begin
              op <= '0;
              if (pc == 2'd2) begin
                state <= S_FIN;
              end else begin
                pc     <= pc + 1'b1;
                launch <= 1'b1;
              end
            end else begin
              op     <= op + 1'b1;
              launch <= 1'b1;
            end
          end
        end
        S_FIN: begin
          vel.vel_x      <= kve_pkg::sat32(v[0]);
          vel.vel_y      <= kve_pkg::sat32(v[1]);
          vel.vel_z      <= kve_pkg::sat32(v[2]);
          vel.next_vel_x <= kve_pkg::sat32(nv[0] - v[0]);
          vel.next_vel_y <= kve_pkg::sat32(nv[1] - v[1]);
          vel.next_vel_z <= kve_pkg::sat32(nv[2] - v[2]);
          vel.ang_x      <= kve_pkg::sat32(w[0]);
          vel.ang_y      <= kve_pkg::sat32(w[1]);
          vel.ang_z      <= kve_pkg::sat32(w[2]);
          vel.next_ang_x <= kve_pkg::sat32(nw[0] - w[0]);
          vel.next_ang_y <= kve_pkg::sat32(nw[1] - w[1]);
          vel.next_ang_z <= kve_pkg::sat32(nw[2] - w[2]);
          for (int i = 0; i < 3; i++) begin
            pr[i] <= pp[i];
            pp[i] <= np[i];
          end
          for (int i = 0; i < 9; i++) begin
            pro[i] <= po[i];
            po[i]  <= no[i];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (vel.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== bench/tb_kinematic_velocity_estimator.sv =====
`timescale 1ns / 100ps

module tb_kinematic_velocity_estimator;

  localparam int CYCLE_LIMIT = 4000000;

  localparam int POS_W     = kve_pkg::POS_W;
  localparam int ORI_W     = kve_pkg::ORI_W;
  localparam int OUT_W     = kve_pkg::OUT_W;
  localparam int STEP_W    = kve_pkg::STEP_W;
  localparam int CFG_IDX_W = kve_pkg::CFG_IDX_W;

  localparam logic [STEP_W-1:0]    STEP_RESET    = kve_pkg::STEP_RESET;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = kve_pkg::REG_STEP;
  localparam logic [CFG_IDX_W-1:0] REG_PREV_STEP = kve_pkg::REG_PREV_STEP;
  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B   = 2'd3;

  typedef struct packed {
    logic [2:0][POS_W-1:0] pos;
    logic [8:0][ORI_W-1:0] ori;   // column-major: c0_x, c0_y, c0_z, c1_x ...
  } pose_t;

  // 0..2 vel, 3..5 next_vel, 6..8 ang, 9..11 next_ang
  typedef logic [11:0][OUT_W-1:0] vel_set_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [STEP_W-1:0] cfg_data;

  kve_pose_if pose ();
  kve_vel_if vel ();

  kinematic_velocity_estimator DUT (
    .clk(clk), .rst(rst), .pose(pose.sink), .vel(vel.source),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // mirror of the block's state
  longint unsigned h_step, oh_step;
  longint prior_pos[3], pend_pos[3], prior_ori[9], pend_ori[9];

  vel_set_t expected_vels[$];
  int errors;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;

  string field_names[12] = '{"vel_x", "vel_y", "vel_z", "next_vel_x", "next_vel_y",
                             "next_vel_z", "ang_x", "ang_y", "ang_z", "next_ang_x",
                             "next_ang_y", "next_ang_z"};

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // round(a * c / 2^sh), half away from zero
  function automatic longint scale_round(longint a, longint unsigned c, int sh);
    logic [127:0] p;
    longint unsigned m;
    longint r;
    m = (a < 0) ? longint'(-a) : longint'(a);
    p = {64'd0, m} * {64'd0, c};
    p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    r = longint'({2'b00, p[61:0]});
    return (a < 0) ? -r : r;
  endfunction

  function automatic logic [OUT_W-1:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic void skew_sum(input longint d[9], input longint a[9], output longint s[3]);
    s[0] = d[2] * a[1] + d[5] * a[4] + d[8] * a[7];
    s[1] = d[0] * a[2] + d[3] * a[5] + d[6] * a[8];
    s[2] = d[1] * a[0] + d[4] * a[3] + d[7] * a[6];
  endfunction

  function automatic vel_set_t estimate_velocities(pose_t p);
    longint unsigned h, oh, khalf, ktwo, dena, denb, ka, kb;
    longint np[3], no[9], d1[9], d2[9], s1[3], s2[3], v[3], w[3], nv, nw;
    vel_set_t r;
    bit eq;
    h = (h_step == 0) ? 1 : h_step;
    oh = (oh_step == 0) ? 1 : oh_step;
    eq = (h == oh);
    khalf = ((64'd1 << 47) + h / 2) / h;
    ktwo = ((64'd1 << 49) + h / 2) / h;
    dena = (h + oh) * h;
    denb = (h + oh) * oh;
    ka = ((oh << 48) + dena / 2) / dena;
    kb = ((h << 48) + denb / 2) / denb;
    for (int i = 0; i < 3; i++) np[i] = longint'($signed(p.pos[i]));
    for (int i = 0; i < 9; i++) no[i] = longint'($signed(p.ori[i]));

    for (int i = 0; i < 3; i++) begin
      if (eq) v[i] = scale_round(np[i] - prior_pos[i], khalf, 32);
      else v[i] = scale_round(np[i] - pend_pos[i], ka, 32)
                + scale_round(pend_pos[i] - prior_pos[i], kb, 32);
      nv = scale_round(np[i] - pend_pos[i], ktwo, 32) - v[i];
      r[i] = clip32(v[i]);
      r[3 + i] = clip32(nv);
    end

    for (int i = 0; i < 9; i++) begin
      d1[i] = eq ? no[i] - prior_ori[i] : no[i] - pend_ori[i];
      d2[i] = pend_ori[i] - prior_ori[i];
    end
    skew_sum(d1, pend_ori, s1);
    skew_sum(d2, pend_ori, s2);
    for (int i = 0; i < 3; i++)
      w[i] = eq ? scale_round(s1[i], khalf, 48)
                : scale_round(s1[i], ka, 48) + scale_round(s2[i], kb, 48);

    for (int i = 0; i < 9; i++) d1[i] = no[i] - pend_ori[i];
    skew_sum(d1, no, s1);
    for (int i = 0; i < 3; i++) begin
      nw = scale_round(s1[i], ktwo, 48) - w[i];
      r[6 + i] = clip32(w[i]);
      r[9 + i] = clip32(nw);
    end

    prior_pos = pend_pos;
    pend_pos = np;
    prior_ori = pend_ori;
    pend_ori = no;
    return r;
  endfunction

  task automatic send_pose(pose_t p);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      pose.valid = 1'b0;
      @(negedge clk);
    end
    pose.valid = 1'b1;
    {pose.pos_z, pose.pos_y, pose.pos_x} = p.pos;
    {pose.orient_c2_z, pose.orient_c2_y, pose.orient_c2_x,
     pose.orient_c1_z, pose.orient_c1_y, pose.orient_c1_x,
     pose.orient_c0_z, pose.orient_c0_y, pose.orient_c0_x} = p.ori;
    do @(posedge clk); while (!pose.ready);
    expected_vels.push_back(estimate_velocities(p));
    @(negedge clk);
  endtask

  task automatic drain();
    pose.valid = 1'b0;
    wait (expected_vels.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == REG_STEP) h_step = 64'(value);
    else if (idx == REG_PREV_STEP) oh_step = 64'(value);
  endtask

  task automatic set_steps(logic [STEP_W-1:0] h, logic [STEP_W-1:0] oh);
    drain();
    write_reg(REG_STEP, h);
    write_reg(REG_PREV_STEP, oh);
  endtask

  function automatic pose_t make_pose(longint posv, logic [ORI_W-1:0] oriv);
    pose_t p;
    for (int i = 0; i < 3; i++) p.pos[i] = posv[31:0];
    for (int i = 0; i < 9; i++) p.ori[i] = oriv;
    return p;
  endfunction

  function automatic logic [ORI_W-1:0] rand_orient();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 18'($urandom());                 // any 18-bit pattern
    if (k == 1) return ($urandom_range(1)) ? 18'sd65536 : -18'sd65536;
    return 18'($signed($urandom_range(131072)) - 65536);
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    int k;
    k = $urandom_range(3);
    for (int i = 0; i < 3; i++) begin
      if (k == 0) p.pos[i] = $urandom();
      else if (k == 1) p.pos[i] = 32'($signed($urandom_range(2000)) - 1000);
      else p.pos[i] = pend_pos[i][31:0] + 32'($signed($urandom_range(131072)) - 65536);
    end
    for (int i = 0; i < 9; i++) p.ori[i] = rand_orient();
    return p;
  endfunction

  always @(negedge clk) begin
    if (rst) vel.ready <= 1'b0;
    else if (hold_cycles > 0) begin
      vel.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else
      vel.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    vel_set_t got, want;
    if (!rst && vel.valid && vel.ready) begin
      got = {vel.next_ang_z, vel.next_ang_y, vel.next_ang_x, vel.ang_z, vel.ang_y, vel.ang_x,
             vel.next_vel_z, vel.next_vel_y, vel.next_vel_x, vel.vel_z, vel.vel_y, vel.vel_x};
      if (expected_vels.size() == 0) begin
        $display("%0t: unexpected velocity transfer", $time);
        errors++;
      end else begin
        want = expected_vels.pop_front();
        for (int i = 0; i < 12; i++)
          if (got[i] !== want[i]) begin
            $display("%0t: %s expected %0d actual %0d", $time, field_names[i],
                     $signed(want[i]), $signed(got[i]));
            errors++;
          end
      end
    end
  end

  task automatic test_extremes();
    pose_t p;
    send_pose(make_pose(64'sd2147483647, 18'sd65536));
    send_pose(make_pose(-64'sd2147483648, -18'sd65536));
    send_pose(make_pose(64'sd2147483647, 18'sd65536));
    send_pose(make_pose(64'sd0, 18'sd0));
    // out-of-range orientation patterns
    send_pose(make_pose(-64'sd1, 18'h1ffff));
    send_pose(make_pose(64'sd1, 18'h20000));
    p = make_pose(64'sd65536, 18'sd0);
    p.ori[0] = 18'sd65536; p.ori[4] = 18'sd65536; p.ori[8] = 18'sd65536;
    send_pose(p);
    p.ori[1] = 18'sd46341; p.ori[3] = -18'sd46341;
    p.ori[0] = 18'sd46341; p.ori[4] = 18'sd46341;
    send_pose(p);
  endtask

  task automatic test_step_settings();
    // unequal steps at both extremes, then zero steps, then ignored indexes
    set_steps(16'd1, 16'd65535);
    for (int i = 0; i < 4; i++) send_pose(rand_pose());
    send_pose(make_pose(64'sd2147483647, 18'sd65536));
    set_steps(16'd65535, 16'd1);
    send_pose(make_pose(-64'sd2147483648, -18'sd65536));
    for (int i = 0; i < 3; i++) send_pose(rand_pose());
    set_steps(16'd0, 16'd0);
    for (int i = 0; i < 3; i++) send_pose(rand_pose());
    set_steps(16'd0, 16'd1);
    send_pose(rand_pose());
    drain();
    write_reg(REG_SPARE_A, 16'd7);
    write_reg(REG_SPARE_B, 16'hffff);
    send_pose(rand_pose());
    set_steps(16'd1, 16'd1);
    send_pose(make_pose(64'sd2147483647, 18'sd65536));
  endtask

  task automatic test_random_phase(int idle, int stall, int count);
    logic [STEP_W-1:0] h;
    drain();
    send_idle_pct = idle;
    recv_stall_pct = stall;
    case ($urandom_range(3))
      0: set_steps(STEP_RESET, STEP_RESET);
      1: begin
        h = 16'($urandom_range(65535, 1));
        set_steps(h, h);
      end
      2: set_steps(16'($urandom_range(65535)), 16'($urandom_range(65535)));
      default: set_steps(16'($urandom_range(2000, 1)), 16'($urandom_range(2000, 1)));
    endcase
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 59)
        set_steps(16'($urandom_range(65535)), 16'($urandom_range(65535)));
      send_pose(rand_pose());
    end
  endtask

  task automatic test_backpressure();
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    hold_cycles = 4000;
    for (int i = 0; i < 5; i++) send_pose(rand_pose());
    // pause until everything has come back, then resume
    drain();
    for (int i = 0; i < 5; i++) send_pose(rand_pose());
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pose.valid = 1'b0;
    {pose.pos_x, pose.pos_y, pose.pos_z} = '0;
    {pose.orient_c0_x, pose.orient_c0_y, pose.orient_c0_z} = '0;
    {pose.orient_c1_x, pose.orient_c1_y, pose.orient_c1_z} = '0;
    {pose.orient_c2_x, pose.orient_c2_y, pose.orient_c2_z} = '0;
    h_step = 64'(STEP_RESET);
    oh_step = 64'(STEP_RESET);
    for (int i = 0; i < 3; i++) begin
      prior_pos[i] = 0;
      pend_pos[i] = 0;
    end
    for (int i = 0; i < 9; i++) begin
      prior_ori[i] = 0;
      pend_ori[i] = 0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_extremes();
    test_step_settings();
    test_random_phase(0, 0, 250);
    test_random_phase(60, 0, 250);
    test_random_phase(0, 60, 250);
    test_random_phase(14, 14, 250);
    test_backpressure();

    drain();
    repeat (700) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
